// ===== hdl/fixed_capacity_multiset_bag_macros.svh =====
// ---------------------------------------------------------------------------
// Multiset bag assertion macros
// Concurrent assertion wrappers used by the bag controller.
// ---------------------------------------------------------------------------
`ifndef FIXED_CAPACITY_MULTISET_BAG_MACROS_SVH
`define FIXED_CAPACITY_MULTISET_BAG_MACROS_SVH

// same-cycle implication
`define FCMB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fcmb assertion failed");

// next-cycle implication
`define FCMB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fcmb assertion failed");

`endif

// ===== hdl/fcmb_pkg.sv =====
// ---------------------------------------------------------------------------
// Multiset bag package
// Sizes, opcodes, state encoding and shared structs of the bag.
// ---------------------------------------------------------------------------
package fcmb_pkg;

   localparam int CAPACITY    = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int DATA_W      = 32;
   localparam int SIZE_W      = 5;
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   typedef enum logic [2:0] {
      OP_ADD    = 3'd0,
      OP_REMOVE = 3'd1,
      OP_QUERY  = 3'd2,
      OP_CLEAR  = 3'd3,
      OP_DUMP   = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                   shift;
      logic                   wr_en;
      logic [IDX_W-1:0]       wr_idx;
      logic [VALUE_WIDTH-1:0] wr_data;
   } ring_ctl_type;

   typedef struct packed {
      logic              last;
      logic [DATA_W-1:0] dump_value;
      logic              is_empty;
      logic [SIZE_W-1:0] size;
      logic [SIZE_W-1:0] frequency;
      logic              found;
      logic              ok;
   } rsp_type;

endpackage

// ===== hdl/fcmb_cell.sv =====
// ---------------------------------------------------------------------------
// Multiset bag storage cell
// One entry of the rotating ring: load on write, take neighbor on shift.
// ---------------------------------------------------------------------------
module fcmb_cell (
   input  logic                            clock,
   input  fcmb_pkg::ring_ctl_type          ctl,
   input  logic                            sel,
   input  logic [fcmb_pkg::VALUE_WIDTH-1:0] nbr_value,
   output logic [fcmb_pkg::VALUE_WIDTH-1:0] value
);

   logic [fcmb_pkg::VALUE_WIDTH-1:0] data_ff;
   logic [fcmb_pkg::VALUE_WIDTH-1:0] data_in;

   always_comb begin
      priority if (ctl.wr_en && sel) begin
         data_in = ctl.wr_data;
      end else if (ctl.shift) begin
         data_in = nbr_value;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign value = data_ff;

endmodule

// ===== hdl/fcmb_ctrl.sv =====
// ---------------------------------------------------------------------------
// Multiset bag controller
// Sequences requests, scans the ring head with one comparator, holds results.
// ---------------------------------------------------------------------------
`include "fixed_capacity_multiset_bag_macros.svh"

module fcmb_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [2:0]                        req_op,
   input  logic [fcmb_pkg::VALUE_WIDTH-1:0]  req_key,
   input  logic [fcmb_pkg::VALUE_WIDTH-1:0]  head,
   output fcmb_pkg::ring_ctl_type            ring,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output fcmb_pkg::rsp_type                 rsp
);

   localparam int CNT_W = fcmb_pkg::CNT_W;
   localparam int IDX_W = fcmb_pkg::IDX_W;

   fcmb_pkg::state_type              state_ff, state_in;
   fcmb_pkg::op_type                 op_ff, op_in;
   logic [fcmb_pkg::VALUE_WIDTH-1:0] key_ff, key_in;
   logic [fcmb_pkg::VALUE_WIDTH-1:0] last_val_ff, last_val_in;
   logic [IDX_W-1:0]                 step_ff, step_in;
   logic [IDX_W-1:0]                 at_ff, at_in;
   logic                             hit_ff, hit_in;
   logic [CNT_W-1:0]                 freq_ff, freq_in;
   logic [CNT_W-1:0]                 count_ff, count_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   fcmb_pkg::rsp_type                rsp_ff, rsp_in;

   logic             accept;
   logic             can_load;
   logic [CNT_W-1:0] k_ext;
   logic             in_range;
   logic             at_last_entry;
   logic             scan_end;
   logic             match;
   logic             advance;
   logic             load;
   fcmb_pkg::rsp_type rsp_d;

   assign can_load      = !rsp_valid_ff || rsp_ready;
   assign req_ready     = (state_ff == fcmb_pkg::ST_IDLE) && can_load;
   assign accept        = req_valid && req_ready;
   assign k_ext         = CNT_W'(step_ff);
   assign in_range      = k_ext < count_ff;
   assign at_last_entry = (k_ext + CNT_W'(1)) == count_ff;
   assign scan_end      = step_ff == IDX_W'(fcmb_pkg::CAPACITY - 1);
   assign match         = in_range && (head == key_ff);
   assign advance       = (state_ff == fcmb_pkg::ST_SCAN) &&
                          !((op_ff == fcmb_pkg::OP_DUMP) && in_range && !can_load);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fcmb_pkg::ST_IDLE: begin
            if (accept) begin
               if ((fcmb_pkg::op_type'(req_op) == fcmb_pkg::OP_REMOVE) ||
                   (fcmb_pkg::op_type'(req_op) == fcmb_pkg::OP_QUERY) ||
                   ((fcmb_pkg::op_type'(req_op) == fcmb_pkg::OP_DUMP) &&
                    (count_ff != '0))) begin
                  state_in = fcmb_pkg::ST_SCAN;
               end
            end
         end
         fcmb_pkg::ST_SCAN: begin
            if (advance && scan_end) begin
               state_in = (op_ff == fcmb_pkg::OP_DUMP) ? fcmb_pkg::ST_IDLE
                                                       : fcmb_pkg::ST_DONE;
            end
         end
         fcmb_pkg::ST_DONE: begin
            if (can_load) begin
               state_in = fcmb_pkg::ST_IDLE;
            end
         end
         default: state_in = fcmb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      op_in         = op_ff;
      key_in        = key_ff;
      last_val_in   = last_val_ff;
      step_in       = step_ff;
      at_in         = at_ff;
      hit_in        = hit_ff;
      freq_in       = freq_ff;
      count_in      = count_ff;
      ring.shift    = 1'b0;
      ring.wr_en    = 1'b0;
      ring.wr_idx   = IDX_W'(count_ff);
      ring.wr_data  = req_key;
      load          = 1'b0;
      rsp_d         = '0;
      rsp_d.last    = 1'b1;

      unique case (state_ff)
         fcmb_pkg::ST_IDLE: begin
            if (accept) begin
               op_in   = fcmb_pkg::op_type'(req_op);
               key_in  = req_key;
               step_in = '0;
               at_in   = '0;
               hit_in  = 1'b0;
               freq_in = '0;
               unique case (fcmb_pkg::op_type'(req_op))
                  fcmb_pkg::OP_ADD: begin
                     load = 1'b1;
                     if (count_ff < CNT_W'(fcmb_pkg::CAPACITY)) begin
                        ring.wr_en = 1'b1;
                        count_in   = count_ff + CNT_W'(1);
                        rsp_d.ok   = 1'b1;
                     end
                  end
                  fcmb_pkg::OP_REMOVE, fcmb_pkg::OP_QUERY: begin
                  end
                  fcmb_pkg::OP_CLEAR: begin
                     load     = 1'b1;
                     count_in = '0;
                  end
                  fcmb_pkg::OP_DUMP: begin
                     load = (count_ff == '0);
                  end
                  default: load = 1'b1;
               endcase
            end
         end
         fcmb_pkg::ST_SCAN: begin
            if (advance) begin
               ring.shift = 1'b1;
               step_in    = step_ff + IDX_W'(1);
               if (at_last_entry) begin
                  last_val_in = head;
               end
               if (match) begin
                  freq_in = freq_ff + CNT_W'(1);
                  if (!hit_ff) begin
                     hit_in = 1'b1;
                     at_in  = step_ff;
                  end
               end
               if ((op_ff == fcmb_pkg::OP_DUMP) && in_range) begin
                  load             = 1'b1;
                  rsp_d.ok         = 1'b1;
                  rsp_d.dump_value = fcmb_pkg::DATA_W'(head);
                  rsp_d.last       = at_last_entry;
               end
            end
         end
         fcmb_pkg::ST_DONE: begin
            if (can_load) begin
               load = 1'b1;
               if (op_ff == fcmb_pkg::OP_REMOVE) begin
                  rsp_d.ok = hit_ff;
                  if (hit_ff) begin
                     ring.wr_en   = 1'b1;
                     ring.wr_idx  = at_ff;
                     ring.wr_data = last_val_ff;
                     count_in     = count_ff - CNT_W'(1);
                  end
               end else begin
                  rsp_d.found     = (freq_ff != '0);
                  rsp_d.frequency = fcmb_pkg::SIZE_W'(freq_ff);
               end
            end
         end
         default: begin
         end
      endcase

      rsp_d.size     = fcmb_pkg::SIZE_W'(count_in);
      rsp_d.is_empty = (count_in == '0);
      rsp_in         = load ? rsp_d : rsp_ff;
      rsp_valid_in   = load ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fcmb_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      key_ff      <= key_in;
      last_val_ff <= last_val_in;
      step_ff     <= step_in;
      at_ff       <= at_in;
      hit_ff      <= hit_in;
      freq_ff     <= freq_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `FCMB_ASSERT_NOW(a_count_bound, clock, reset, 1'b1,
      count_ff <= CNT_W'(fcmb_pkg::CAPACITY))
   `FCMB_ASSERT_NEXT(a_accept_busy, clock, reset, accept,
      rsp_valid_ff || (state_ff != fcmb_pkg::ST_IDLE))
   `FCMB_ASSERT_NOW(a_shift_in_scan, clock, reset, ring.shift,
      state_ff == fcmb_pkg::ST_SCAN)
   `FCMB_ASSERT_NOW(a_remove_nonempty, clock, reset,
      (state_ff == fcmb_pkg::ST_DONE) && (op_ff == fcmb_pkg::OP_REMOVE) && hit_ff,
      count_ff != '0)

endmodule

// ===== hdl/fixed_capacity_multiset_bag.sv =====
// ---------------------------------------------------------------------------
// Fixed-capacity multiset bag
// Unordered bag of up to 16 values held in a rotating ring of cells.
// ---------------------------------------------------------------------------
// Requests enter on the req_ stream (op in tuser, value in tdata); results
// leave on the rsp_ stream, one per request, or one per entry for a dump,
// with tlast on the final result of each request.
// Add, clear and unknown ops answer from the output register in the cycle
// after acceptance. Remove, query and dump rotate the ring once through all
// 16 cells, comparing the head cell on one comparator per cycle unless a
// stalled dump result holds the ring. A dump emits one entry per rotation
// step.
// A new request is taken only while the controller is idle and the output
// register is free or being drained. When the receiver stalls, the ring holds
// its position during a dump and the result register holds its transaction.
// Reset empties the bag and drops any pending result; entry storage is not
// cleared and entries beyond the count are never read.
// ---------------------------------------------------------------------------
module fixed_capacity_multiset_bag (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // value[31:0]
   input  logic [7:0]  req_tuser,  // op[2:0], zero[7:3]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // ok[0], found[1], frequency[6:2], size[11:7],
                                   // is_empty[12], dump_value[44:13], zero[47:45]
   output logic        rsp_tlast
);

   localparam int CAP = fcmb_pkg::CAPACITY;

   fcmb_pkg::ring_ctl_type           ring;
   fcmb_pkg::rsp_type                rsp;
   logic [fcmb_pkg::VALUE_WIDTH-1:0] cell_value [CAP];

   fcmb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_op    (req_tuser[2:0]),
      .req_key   (req_tdata[fcmb_pkg::VALUE_WIDTH-1:0]),
      .head      (cell_value[0]),
      .ring      (ring),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   for (genvar i = 0; i < CAP; i++) begin : g_cell
      fcmb_cell u_cell (
         .clock     (clock),
         .ctl       (ring),
         .sel       (ring.wr_idx == fcmb_pkg::IDX_W'(i)),
         .nbr_value (cell_value[(i + 1) % CAP]),
         .value     (cell_value[i])
      );
   end

   assign rsp_tdata = {3'b000, rsp.dump_value, rsp.is_empty, rsp.size,
                       rsp.frequency, rsp.found, rsp.ok};
   assign rsp_tlast = rsp.last;

endmodule

// ===== tb/fcmb_result_checker.sv =====
// ---------------------------------------------------------------------------
// Multiset bag result checker
// Watches the request and result streams, keeps its own copy of the bag,
// predicts every result and compares it field by field in arrival order.
// ---------------------------------------------------------------------------
module fcmb_result_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,  // value[31:0]
   input  logic [7:0]  req_tuser,  // op[2:0], zero[7:3]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,  // ok[0], found[1], frequency[6:2], size[11:7],
                                   // is_empty[12], dump_value[44:13], zero[47:45]
   input  logic        rsp_tlast,
   output int          fault_count,
   output int          awaited_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY    = fcmb_pkg::CAPACITY;
   localparam int VALUE_WIDTH = fcmb_pkg::VALUE_WIDTH;
   localparam int DATA_W      = fcmb_pkg::DATA_W;
   localparam int SIZE_W      = fcmb_pkg::SIZE_W;

   typedef struct {
      logic              ok;
      logic              found;
      logic [SIZE_W-1:0] frequency;
      logic [SIZE_W-1:0] size;
      logic              is_empty;
      logic [DATA_W-1:0] dump_value;
      logic              last;
   } bag_result_type;

   logic [VALUE_WIDTH-1:0] bag_store [CAPACITY];
   int unsigned            bag_count = 0;
   bag_result_type         results_due [$];
   int                     faults = 0;
   int                     awaited = 0;

   assign fault_count   = faults;
   assign awaited_count = awaited;

   function automatic void push_result(logic ok, logic found, logic [SIZE_W-1:0] frequency,
                                       logic [DATA_W-1:0] dump_value, logic last);
      bag_result_type r;
      r.ok         = ok;
      r.found      = found;
      r.frequency  = frequency;
      r.size       = SIZE_W'(bag_count);
      r.is_empty   = (bag_count == 0);
      r.dump_value = dump_value;
      r.last       = last;
      results_due  = {results_due, r};
   endfunction

   function automatic void predict_bag_op(logic [2:0] op, logic [31:0] raw_value);
      logic [VALUE_WIDTH-1:0] v;
      int unsigned            hits;
      int                     at;
      v    = raw_value[VALUE_WIDTH-1:0];
      hits = 0;
      at   = -1;
      case (op)
         fcmb_pkg::OP_ADD: begin
            if (bag_count < CAPACITY) begin
               bag_store[bag_count] = v;
               bag_count++;
               push_result(1'b1, 1'b0, '0, '0, 1'b1);
            end else begin
               push_result(1'b0, 1'b0, '0, '0, 1'b1);
            end
         end
         fcmb_pkg::OP_REMOVE: begin
            for (int i = 0; i < bag_count; i++) begin
               if (at < 0 && bag_store[i] == v) at = i;
            end
            if (at >= 0) begin
               bag_count--;
               bag_store[at] = bag_store[bag_count];
            end
            push_result(at >= 0, 1'b0, '0, '0, 1'b1);
         end
         fcmb_pkg::OP_QUERY: begin
            for (int i = 0; i < bag_count; i++) begin
               if (bag_store[i] == v) hits++;
            end
            push_result(1'b0, hits > 0, SIZE_W'(hits), '0, 1'b1);
         end
         fcmb_pkg::OP_CLEAR: begin
            bag_count = 0;
            push_result(1'b0, 1'b0, '0, '0, 1'b1);
         end
         fcmb_pkg::OP_DUMP: begin
            if (bag_count == 0) begin
               push_result(1'b0, 1'b0, '0, '0, 1'b1);
            end else begin
               for (int i = 0; i < bag_count; i++) begin
                  push_result(1'b1, 1'b0, '0, DATA_W'(bag_store[i]), i + 1 == bag_count);
               end
            end
         end
         default: begin
            push_result(1'b0, 1'b0, '0, '0, 1'b1);
         end
      endcase
   endfunction

   function automatic void compare_field(string field_name, logic [DATA_W-1:0] want,
                                         logic [DATA_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field_name, want, got);
         faults++;
      end
   endfunction

   always @(posedge clock) begin : watch
      bag_result_type want;
      if (reset) begin
         bag_count = 0;
         results_due.delete();
      end else begin
         if (req_tvalid && req_tready) predict_bag_op(req_tuser[2:0], req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (results_due.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h last %b",
                        $time, rsp_tdata, rsp_tlast);
               faults++;
            end else begin
               want = results_due.pop_front();
               compare_field("ok",         DATA_W'(want.ok),        DATA_W'(rsp_tdata[0]));
               compare_field("found",      DATA_W'(want.found),     DATA_W'(rsp_tdata[1]));
               compare_field("frequency",  DATA_W'(want.frequency), DATA_W'(rsp_tdata[6:2]));
               compare_field("size",       DATA_W'(want.size),      DATA_W'(rsp_tdata[11:7]));
               compare_field("is_empty",   DATA_W'(want.is_empty),  DATA_W'(rsp_tdata[12]));
               compare_field("dump_value", want.dump_value,         rsp_tdata[44:13]);
               compare_field("last",       DATA_W'(want.last),      DATA_W'(rsp_tlast));
            end
         end
      end
      awaited = results_due.size();
   end

endmodule

// ===== tb/tb_fixed_capacity_multiset_bag.sv =====
// ---------------------------------------------------------------------------
// Multiset bag testbench
// Directed bag operations followed by random request mixes and fill bursts,
// with random idling on both streams; results are checked by the checker.
// ---------------------------------------------------------------------------
module tb_fixed_capacity_multiset_bag;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         CAPACITY       = fcmb_pkg::CAPACITY;
   localparam logic [2:0] OP_RESERVED_LO = 3'd5;
   localparam logic [2:0] OP_RESERVED_HI = 3'd7;
   localparam int         RANDOM_ITEMS   = 378;
   localparam int         DRAIN_CYCLES   = 40;
   localparam int         CYCLE_LIMIT    = 1000000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic [7:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;

   int          fault_count;
   int          awaited_count;
   int          cycle_count = 0;
   int          ready_hold  = 0;
   bit          no_idle     = 1'b0;
   logic [31:0] value_pool [8];

   fixed_capacity_multiset_bag i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   fcmb_result_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .fault_count   (fault_count),
      .awaited_count (awaited_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic int draw_wait();
      return no_idle ? 0 : $urandom_range(0, 13);
   endfunction

   // hold ready low for a drawn number of cycles after each result transaction
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_hold = 0;
      end else if (ready_hold > 0) begin
         ready_hold--;
         if (ready_hold == 0) rsp_tready <= 1'b1;
      end else if (!rsp_tready) begin
         rsp_tready <= 1'b1;
      end else if (rsp_tvalid) begin
         ready_hold = draw_wait();
         if (ready_hold > 0) rsp_tready <= 1'b0;
      end
   end

   task automatic send_request(input logic [2:0] op, input logic [31:0] value);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= {5'b0, op};
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic void refresh_pool();
      value_pool[0] = '0;
      value_pool[1] = '1;
      for (int i = 2; i < 8; i++) value_pool[i] = $urandom;
   endfunction

   function automatic logic [31:0] pick_value();
      return ($urandom_range(0, 3) != 0) ? value_pool[$urandom_range(0, 7)] : $urandom;
   endfunction

   task automatic send_fill_burst();
      logic [31:0] v;
      refresh_pool();
      send_request(fcmb_pkg::OP_CLEAR, $urandom);
      for (int i = 0; i <= CAPACITY; i++) send_request(fcmb_pkg::OP_ADD, pick_value());
      v = pick_value();
      send_request(fcmb_pkg::OP_QUERY, v);
      send_request(fcmb_pkg::OP_REMOVE, v);
      send_request(fcmb_pkg::OP_DUMP, $urandom);
   endtask

   task automatic send_random_request();
      int r;
      r = $urandom_range(0, 99);
      if (r < 38)      send_request(fcmb_pkg::OP_ADD,    pick_value());
      else if (r < 58) send_request(fcmb_pkg::OP_REMOVE, pick_value());
      else if (r < 76) send_request(fcmb_pkg::OP_QUERY,  pick_value());
      else if (r < 86) send_request(fcmb_pkg::OP_DUMP,   $urandom);
      else if (r < 92) send_request(fcmb_pkg::OP_CLEAR,  $urandom);
      else             send_request(3'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI)), $urandom);
   endtask

   initial begin
      int sent;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_request(fcmb_pkg::OP_DUMP,   $urandom);
      send_request(fcmb_pkg::OP_REMOVE, 32'h0000_0001);
      send_request(fcmb_pkg::OP_QUERY,  32'h0000_0000);
      send_request(fcmb_pkg::OP_ADD,    32'h0000_0000);
      send_request(fcmb_pkg::OP_ADD,    32'hFFFF_FFFF);
      send_request(fcmb_pkg::OP_ADD,    32'h1234_5678);
      send_request(fcmb_pkg::OP_ADD,    32'h0000_0000);
      send_request(fcmb_pkg::OP_QUERY,  32'h0000_0000);
      send_request(fcmb_pkg::OP_REMOVE, 32'h0000_0000);
      send_request(fcmb_pkg::OP_DUMP,   $urandom);
      send_request(OP_RESERVED_LO, $urandom);
      send_request(OP_RESERVED_HI, $urandom);
      send_request(fcmb_pkg::OP_CLEAR,  $urandom);
      for (int i = 0; i < CAPACITY; i++) send_request(fcmb_pkg::OP_ADD, 32'hA5A5_5A5A);
      send_request(fcmb_pkg::OP_ADD,    32'hFFFF_FFFF);
      send_request(fcmb_pkg::OP_QUERY,  32'hA5A5_5A5A);
      send_request(fcmb_pkg::OP_DUMP,   $urandom);

      refresh_pool();
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 99) < 4) no_idle = !no_idle;
         if ($urandom_range(0, 99) < 5) begin
            send_fill_burst();
            sent += CAPACITY + 5;
         end else begin
            if ($urandom_range(0, 49) == 0) refresh_pool();
            send_random_request();
            sent++;
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaited_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0 && awaited_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
